[rtl/nrmac_pkg.sv]
// Shared types, codes and LCID lookup functions for the NR MAC PDU parser.
// No dependencies; imported by nrmac_step and nr_mac_pdu_demux_parser.
`timescale 1ns / 1ps

package nrmac_pkg;

  typedef enum logic [2:0] {
    PH_SUBHDR,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_PADDING,
    PH_DISCARD
  } phase_e;

  localparam logic [2:0] ROLE_SUBHDR  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd2;
  localparam logic [2:0] ROLE_PADDING = 3'd3;
  localparam logic [2:0] ROLE_DISCARD = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_LCID  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  localparam logic [5:0] LCID_MASK          = 6'h3f;
  localparam logic [5:0] LCID_SDU_MAX       = 6'd32;
  localparam logic [5:0] LCID_UL_CE_MIN     = 6'd52;
  localparam logic [5:0] LCID_DL_CE_MIN     = 6'd47;
  localparam logic [5:0] LC_CCCH64          = 6'd0;
  localparam logic [5:0] LC_CCCH48          = 6'd52;
  localparam logic [5:0] LC_SE_PHR          = 6'd57;
  localparam logic [5:0] LC_CRNTI           = 6'd58;
  localparam logic [5:0] LC_SHORT_TRUNC_BSR = 6'd59;
  localparam logic [5:0] LC_LONG_TRUNC_BSR  = 6'd60;
  localparam logic [5:0] LC_TA_OR_SBSR      = 6'd61;
  localparam logic [5:0] LC_CRID_OR_LBSR    = 6'd62;
  localparam logic [5:0] LC_PAD             = 6'd63;

  typedef struct packed {
    phase_e      phase;
    logic [5:0]  channel;
    logic        long_len;
    logic [15:0] length;
    logic [15:0] position;
    logic        err_latched;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [5:0]  channel;
    logic [15:0] body_length;
    logic        is_sdu;
    logic [7:0]  data;
    logic [15:0] index;
    logic        subpdu_end;
    logic [1:0]  error;
    logic        pdu_done;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_SUBHDR,
    channel:     6'd0,
    long_len:    1'b0,
    length:      16'd0,
    position:    16'd0,
    err_latched: 1'b0
  };

  function automatic logic lcid_valid(input logic [5:0] l, input logic ul);
    logic ok;
    if (l <= LCID_SDU_MAX) begin
      ok = 1'b1;
    end else if (ul) begin
      ok = (l >= LCID_UL_CE_MIN);
    end else begin
      ok = (l >= LCID_DL_CE_MIN);
    end
    return ok;
  endfunction

  function automatic logic lcid_is_sdu(input logic [5:0] l, input logic ul);
    return (l <= LCID_SDU_MAX) && !(ul && (l == LC_CCCH64));
  endfunction

  function automatic logic lcid_has_len(input logic [5:0] l, input logic ul);
    logic has;
    if (ul && ((l == LC_CCCH64) || (l == LC_CCCH48))) begin
      has = 1'b0;
    end else if (lcid_is_sdu(l, ul)) begin
      has = 1'b1;
    end else begin
      has = ul && ((l == LC_LONG_TRUNC_BSR) || (l == LC_CRID_OR_LBSR));
    end
    return has;
  endfunction

  function automatic logic [15:0] ce_size(input logic [5:0] l, input logic ul);
    logic [15:0] sz;
    sz = 16'd0;
    if (ul) begin
      case (l)
        LC_CCCH48:                         sz = 16'd6;
        LC_CCCH64:                         sz = 16'd8;
        LC_CRNTI:                          sz = 16'd2;
        LC_TA_OR_SBSR, LC_SHORT_TRUNC_BSR: sz = 16'd1;
        LC_SE_PHR:                         sz = 16'd2;
        default:                           sz = 16'd0;
      endcase
    end else begin
      case (l)
        LC_CRID_OR_LBSR: sz = 16'd6;
        LC_TA_OR_SBSR:   sz = 16'd1;
        default:         sz = 16'd0;
      endcase
    end
    return sz;
  endfunction

endpackage

[rtl/nrmac_step.sv]
// Per-byte parse step: labels one PDU byte and computes the next parser state.
// Purely combinational; depends on nrmac_pkg.
`timescale 1ns / 1ps

module nrmac_step import nrmac_pkg::*; (
  input  parse_state_t  state_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          uplink_i,
  output parse_state_t  state_o,
  output parse_result_t result_o
);

  logic [5:0]  lcid;
  logic        hdr_done;
  parse_state_t  nxt;
  parse_result_t res;

  assign lcid = byte_i[5:0] & LCID_MASK;

  always_comb begin
    nxt          = state_i;
    hdr_done     = 1'b0;
    res.role        = ROLE_DISCARD;
    res.channel     = state_i.channel;
    res.body_length = 16'd0;
    res.is_sdu      = 1'b0;
    res.data        = byte_i;
    res.index       = 16'd0;
    res.subpdu_end  = 1'b0;
    res.error       = ERR_NONE;
    res.pdu_done    = last_i;

    unique case (state_i.phase)
      PH_SUBHDR: begin
        res.role    = ROLE_SUBHDR;
        res.channel = lcid;
        nxt.channel = lcid;
        if (!lcid_valid(lcid, uplink_i)) begin
          res.error       = ERR_LCID;
          nxt.err_latched = 1'b1;
          nxt.phase       = PH_DISCARD;
        end else if (lcid == LC_PAD) begin
          nxt.position   = 16'd0;
          nxt.length     = 16'd0;
          nxt.phase      = PH_PADDING;
          res.subpdu_end = last_i;
        end else if (lcid_has_len(lcid, uplink_i)) begin
          nxt.long_len = byte_i[6];
          nxt.length   = 16'd0;
          res.is_sdu   = lcid_is_sdu(lcid, uplink_i);
          nxt.phase    = PH_LEN1;
          if (last_i) begin
            res.error = ERR_TRUNC;
          end
        end else begin
          nxt.length = ce_size(lcid, uplink_i);
          hdr_done   = 1'b1;
        end
      end
      PH_LEN1: begin
        res.role   = ROLE_LENGTH;
        res.is_sdu = lcid_is_sdu(state_i.channel, uplink_i);
        if (state_i.long_len) begin
          nxt.length = {byte_i, 8'd0};
          nxt.phase  = PH_LEN2;
          if (last_i) begin
            res.error = ERR_TRUNC;
          end
        end else begin
          nxt.length = {8'd0, byte_i};
          hdr_done   = 1'b1;
        end
      end
      PH_LEN2: begin
        res.role   = ROLE_LENGTH;
        res.is_sdu = lcid_is_sdu(state_i.channel, uplink_i);
        nxt.length = {state_i.length[15:8], state_i.length[7:0] | byte_i};
        hdr_done   = 1'b1;
      end
      PH_PAYLOAD: begin
        res.role        = ROLE_PAYLOAD;
        res.is_sdu      = lcid_is_sdu(state_i.channel, uplink_i);
        res.body_length = state_i.length;
        res.index       = state_i.position;
        if (({1'b0, state_i.position} + 17'd1) >= {1'b0, state_i.length}) begin
          res.subpdu_end = 1'b1;
          nxt.phase      = PH_SUBHDR;
        end else begin
          nxt.position = state_i.position + 16'd1;
          if (last_i) begin
            res.error = ERR_TRUNC;
          end
        end
      end
      PH_PADDING: begin
        res.role       = ROLE_PADDING;
        res.channel    = LC_PAD;
        res.index      = state_i.position;
        res.subpdu_end = last_i;
        if (state_i.position != 16'hffff) begin
          nxt.position = state_i.position + 16'd1;
        end
      end
      default: begin
        res.role = ROLE_DISCARD;
      end
    endcase

    if (hdr_done) begin
      res.body_length = nxt.length;
      nxt.position    = 16'd0;
      if (nxt.length == 16'd0) begin
        res.subpdu_end = 1'b1;
        nxt.phase      = PH_SUBHDR;
      end else begin
        nxt.phase = PH_PAYLOAD;
        if (last_i) begin
          res.error = ERR_TRUNC;
        end
      end
    end

    if (last_i) begin
      nxt = STATE_RESET;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

[rtl/nr_mac_pdu_demux_parser.sv]
// NR MAC PDU subheader parser: top level with input, state and result registers.
// Depends on nrmac_pkg and nrmac_step.
//
// Usage: the bytes of a MAC PDU enter one word per cycle on the input channel
// (in_valid_i / in_stall_o) with last_byte_i set on the final byte. Every
// accepted word yields exactly one labelled result word on the output channel
// (out_valid_o / out_stall_i), in order.
// Path: an accepted word is registered in the input register, then parsed into the result
// register, which offers it on the output channel until it is taken.
// Throughput: one word per cycle while the receiver does not stall; the only
// loop is the update of the parser state register.
// The direction register (cfg_we_i / cfg_data_i) selects UL-SCH when set and DL-SCH
// when clear; the user must write it only while the block is idle, unchecked by it.
// Reset: clears both valid flags, the direction register (DL-SCH) and the parser
// state, so the first word is taken as a subheader.
// Stall: when out_stall_i holds a result, the input register keeps its word and
// in_stall_o rises only once that register is also full, so one further word
// is taken while a result waits.
`timescale 1ns / 1ps

module nr_mac_pdu_demux_parser import nrmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pdu_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  byte_role_o,
  output logic [5:0]  channel_id_o,
  output logic [15:0] body_length_o,
  output logic        is_data_unit_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] payload_index_o,
  output logic        subpdu_end_o,
  output logic [1:0]  parse_error_o,
  output logic        pdu_done_o
);

  logic          uplink_q;
  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic          s1_last_q;
  logic          out_valid_q;
  parse_state_t  state_q, state_d;
  parse_result_t res_q, res_d;
  logic          out_can_load;
  logic          s1_fire;
  logic          in_accept;

  assign out_can_load = !out_valid_q || !out_stall_i;
  assign s1_fire      = s1_valid_q && out_can_load;
  assign in_stall_o   = s1_valid_q && !out_can_load;
  assign in_accept    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uplink_q <= 1'b0;
    end else if (cfg_we_i) begin
      uplink_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= pdu_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  nrmac_step u_step (
    .state_i  (state_q),
    .byte_i   (s1_byte_q),
    .last_i   (s1_last_q),
    .uplink_i (uplink_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_can_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_role_o     = res_q.role;
  assign channel_id_o    = res_q.channel;
  assign body_length_o   = res_q.body_length;
  assign is_data_unit_o  = res_q.is_sdu;
  assign data_byte_o     = res_q.data;
  assign payload_index_o = res_q.index;
  assign subpdu_end_o    = res_q.subpdu_end;
  assign parse_error_o   = res_q.error;
  assign pdu_done_o      = res_q.pdu_done;

  // A latched LCID error holds the parser in the discard phase until the PDU ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err_latched |-> state_q.phase == PH_DISCARD)
    else $error("error latched outside discard phase");

  // The last word of a PDU leaves the parser in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=>
      state_q.phase == PH_SUBHDR && state_q.length == 16'd0 &&
      state_q.position == 16'd0 && !state_q.err_latched)
    else $error("parser state not cleared after last word");

  // A payload word lies inside its announced length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_role_o == ROLE_PAYLOAD |-> payload_index_o < body_length_o)
    else $error("payload index beyond body length");

  // An LCID error is only ever reported on a subheader word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_error_o == ERR_LCID |-> byte_role_o == ROLE_SUBHDR)
    else $error("LCID error on a non-subheader word");

endmodule
